// File: src/lzfb_pkg.sv
// Package for the flag-bit LZ pixel decompressor.
// Holds the request and result types, the decode phases, the status codes and
// the operation record that passes from the decoder to the pixel back end.
`default_nettype none
package lzfb_pkg;

    localparam int HistAw      = 13;             // 8192-entry history
    localparam int HeaderBytes = 4;
    localparam int FlagBits    = 32;
    localparam int CountBase   = 2;
    localparam logic [16:0] FrameMax  = 17'h10000;
    localparam logic [13:0] LongBias  = 14'd8192;
    localparam logic [13:0] ShortBias = 14'd256;

    localparam logic [0:0] CFG_PACKET_BYTES = 1'b0;
    localparam logic [0:0] CFG_FRAME_PIXELS = 1'b1;

    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_BADREF   = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_ORDER    = 3'd5;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_BIT1      = 4'd1,
        PH_BIT2      = 4'd2,
        PH_BIT3      = 4'd3,
        PH_BIT4      = 4'd4,
        PH_LITERAL   = 4'd5,
        PH_SHORT_OFF = 4'd6,
        PH_LONG_LO   = 4'd7,
        PH_LONG_HI   = 4'd8,
        PH_LONG_CNT  = 4'd9,
        PH_COPY      = 4'd10,
        PH_DONE      = 4'd11,
        PH_OVER      = 4'd12,
        PH_BADREF    = 4'd13,
        PH_TRUNC     = 4'd14
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_value;
        logic [15:0] pixel_position;
        logic        copy_pending;
        logic [2:0]  status;
    } t_out_item;

    // One result to be produced by the back end.
    typedef struct packed {
        logic              has_px;
        logic              is_copy;
        logic [7:0]        value;
        logic [15:0]       pos;
        logic [HistAw-1:0] rd_addr;
        logic              pend;
        logic [2:0]        status;
    } t_op;

    function automatic logic [2:0] status_of(t_phase ph);
        logic [3:0] d;
        d = ph - PH_COPY;
        return (ph >= PH_DONE) ? d[2:0] : ST_RUN;
    endfunction

endpackage
`default_nettype wire

// File: src/lzfb_front.sv
// Decoder front end: header skip, flag bits, token parsing and match checks.
// Depends on lzfb_pkg; emits one operation record per result-producing request.
`default_nettype none
module lzfb_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [0:0]            i_cfg_addr,
    input  wire [16:0]           i_cfg_data,
    input  wire                  i_accept,
    input  lzfb_pkg::t_in_item   i_item,
    output logic                 o_push,
    output lzfb_pkg::t_op        o_op
);
    import lzfb_pkg::*;

    typedef struct packed {
        t_phase      phase;
        logic [5:0]  bits;
        logic [31:0] word;
        logic [1:0]  refill;
        logic [1:0]  scount;
    } t_sett;

    // Checks end of packet, else resolves the held flag bits and checks truncation.
    function automatic t_sett settle(t_sett s_in, logic [16:0] rem);
        t_sett s;
        logic  bit_v;
        logic  is_bit;
        s = s_in;
        if (s.phase == PH_BIT1 && s.refill == 2'd0 && rem == 17'd0) begin
            s.phase = PH_DONE;
        end else begin
            for (int k = 0; k < 4; k++) begin
                is_bit = (s.phase >= PH_BIT1) && (s.phase <= PH_BIT4);
                if (is_bit && s.bits != 6'd0) begin
                    bit_v  = s.word[5'(s.bits - 6'd1)];
                    s.bits = s.bits - 6'd1;
                    case (s.phase)
                        PH_BIT1: s.phase = bit_v ? PH_LITERAL : PH_BIT2;
                        PH_BIT2: s.phase = bit_v ? PH_LONG_LO : PH_BIT3;
                        PH_BIT3: begin
                            s.scount = {bit_v, 1'b0};
                            s.phase  = PH_BIT4;
                        end
                        default: begin
                            s.scount = {s.scount[1], bit_v};
                            s.phase  = PH_SHORT_OFF;
                        end
                    endcase
                end
            end
            if (s.phase >= PH_BIT1 && s.phase <= PH_BIT4) begin
                if (s.refill == 2'd0 ? (rem < 17'(HeaderBytes)) : (rem == 17'd0)) begin
                    s.phase = PH_TRUNC;
                end
            end else if (s.phase >= PH_LITERAL && s.phase <= PH_LONG_CNT
                         && rem == 17'd0) begin
                s.phase = PH_TRUNC;
            end
        end
        return s;
    endfunction

    logic [16:0] r_packet;
    logic [16:0] r_frame;
    t_sett       r_s,    n_s;
    logic [16:0] r_wp,   n_wp;
    logic [16:0] r_bt,   n_bt;
    logic [8:0]  r_pend, n_pend;
    logic [13:0] r_dist, n_dist;
    logic [7:0]  r_lfb,  n_lfb;

    t_op         w_op;
    logic        w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet <= '0;
            r_frame  <= 17'd64000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PACKET_BYTES: r_packet <= i_cfg_data;
                CFG_FRAME_PIXELS: r_frame  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s    <= '{phase: PH_HEADER, bits: '0, word: '0, refill: '0, scount: '0};
            r_wp   <= '0;
            r_bt   <= '0;
            r_pend <= '0;
            r_dist <= '0;
            r_lfb  <= '0;
        end else if (i_accept) begin
            r_s    <= n_s;
            r_wp   <= n_wp;
            r_bt   <= n_bt;
            r_pend <= n_pend;
            r_dist <= n_dist;
            r_lfb  <= n_lfb;
        end
    end

    // Next state and the operation record for the request under decode.
    always_comb begin
        logic [16:0] lim;
        logic [16:0] bt1;
        logic [16:0] rem;
        logic [8:0]  count;
        logic [13:0] mdist;
        logic        start;
        logic        report;
        logic [15:0] word16;

        n_s    = r_s;
        n_wp   = r_wp;
        n_bt   = r_bt;
        n_pend = r_pend;
        n_dist = r_dist;
        n_lfb  = r_lfb;
        w_op   = '0;
        w_push = 1'b0;
        start  = 1'b0;
        report = 1'b0;
        count  = '0;
        mdist  = '0;
        word16 = {i_item.byte_in, r_lfb};

        lim = (r_frame > FrameMax) ? FrameMax : r_frame;
        bt1 = r_bt + 17'd1;
        rem = (r_packet > r_bt) ? (r_packet - r_bt) : 17'd0;

        if (r_s.phase >= PH_DONE) begin
            w_op.status = status_of(r_s.phase);
            w_push      = 1'b1;
        end else if (i_item.func) begin
            if (r_s.phase != PH_COPY) begin
                w_op.status = ST_ORDER;
                w_push      = 1'b1;
            end else begin
                n_wp   = r_wp + 17'd1;
                n_pend = r_pend - 9'd1;
                if (n_pend == 9'd0) begin
                    n_s.phase = PH_BIT1;
                    n_s       = settle(n_s, rem);
                end
                w_op.has_px  = 1'b1;
                w_op.is_copy = 1'b1;
                w_op.pos     = r_wp[15:0];
                w_op.rd_addr = r_wp[HistAw-1:0] - r_dist[HistAw-1:0];
                w_op.pend    = (n_pend != 9'd0);
                w_op.status  = status_of(n_s.phase);
                w_push       = 1'b1;
            end
        end else if (r_s.phase == PH_COPY) begin
            w_op.pend   = 1'b1;
            w_op.status = ST_ORDER;
            w_push      = 1'b1;
        end else begin
            n_bt = bt1;
            rem  = (r_packet > bt1) ? (r_packet - bt1) : 17'd0;
            case (r_s.phase)
                PH_HEADER: begin
                    if (bt1 >= 17'(HeaderBytes)) begin
                        n_s.phase = PH_BIT1;
                        n_s       = settle(n_s, rem);
                    end
                end
                PH_LITERAL: begin
                    if (r_wp >= lim) begin
                        n_s.phase = PH_OVER;
                    end else begin
                        n_wp      = r_wp + 17'd1;
                        n_s.phase = PH_BIT1;
                        n_s       = settle(n_s, rem);
                        w_op.has_px = 1'b1;
                        w_op.value  = i_item.byte_in;
                        w_op.pos    = r_wp[15:0];
                        w_op.status = status_of(n_s.phase);
                        w_push      = 1'b1;
                    end
                end
                PH_SHORT_OFF: begin
                    start = 1'b1;
                    count = 9'({7'd0, r_s.scount} + 9'(CountBase));
                    mdist = ShortBias - {6'd0, i_item.byte_in};
                end
                PH_LONG_LO: begin
                    n_lfb     = i_item.byte_in;
                    n_s.phase = PH_LONG_HI;
                    n_s       = settle(n_s, rem);
                end
                PH_LONG_HI: begin
                    mdist = LongBias - {1'b0, word16[15:3]};
                    if (r_lfb[2:0] != 3'd0) begin
                        start = 1'b1;
                        count = {6'd0, r_lfb[2:0]} + 9'(CountBase);
                    end else begin
                        n_dist    = mdist;
                        n_s.phase = PH_LONG_CNT;
                        n_s       = settle(n_s, rem);
                    end
                end
                PH_LONG_CNT: begin
                    if (i_item.byte_in == 8'd0) begin
                        n_s.phase = PH_DONE;
                    end else begin
                        start = 1'b1;
                        count = {1'b0, i_item.byte_in} + 9'(CountBase);
                        mdist = r_dist;
                    end
                end
                default: begin
                    // Flag refill byte, little-endian into the flag word.
                    case (r_s.refill)
                        2'd0:    n_s.word = {24'd0, i_item.byte_in};
                        2'd1:    n_s.word[15:8]  = i_item.byte_in;
                        2'd2:    n_s.word[23:16] = i_item.byte_in;
                        default: n_s.word[31:24] = i_item.byte_in;
                    endcase
                    n_s.refill = r_s.refill + 2'd1;
                    if (r_s.refill == 2'd3) begin
                        n_s.bits = 6'(FlagBits);
                    end
                    n_s = settle(n_s, rem);
                end
            endcase
            if (start) begin
                report = 1'b1;
                n_dist = mdist;
                if (r_wp > lim || (lim - r_wp) < {8'd0, count}) begin
                    n_s.phase = PH_OVER;
                end else if (r_wp < {3'd0, mdist}) begin
                    n_s.phase = PH_BADREF;
                end else begin
                    n_pend    = count;
                    n_s.phase = PH_COPY;
                end
            end
            if (!w_push && (report || n_s.phase >= PH_DONE)) begin
                w_op.pend   = (n_s.phase == PH_COPY);
                w_op.status = status_of(n_s.phase);
                w_push      = 1'b1;
            end
        end
    end

    always_comb begin
        o_push = i_accept && w_push;
        o_op   = w_op;
    end

endmodule
`default_nettype wire

// File: src/lzfb_queue.sv
// Two-entry queue of operation records between decoder and pixel back end.
// Depends on lzfb_pkg for the record type.
`default_nettype none
module lzfb_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  lzfb_pkg::t_op  i_op,
    input  wire            i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output lzfb_pkg::t_op  o_op
);
    import lzfb_pkg::*;

    t_op        r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_op;
    end

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_op       = r_mem[r_rd];

endmodule
`default_nettype wire

// File: src/lzfb_back.sv
// Pixel back end: history RAM read stage with forwarding, then the result register.
// Depends on lzfb_pkg for the operation record and result types.
`default_nettype none
module lzfb_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_avail,
    input  lzfb_pkg::t_op        i_op,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_stall,
    output lzfb_pkg::t_out_item  o_data
);
    import lzfb_pkg::*;

    logic [7:0] r_hist [1 << HistAw];

    logic       r_s1_valid;
    t_op        r_s1_op;
    logic [7:0] r_s1_rd;
    logic       r_s1_fwd;
    logic [7:0] r_s1_fwd_val;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       s1_move;
    logic [7:0] s1_pix;

    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_pop   = i_avail && (!r_s1_valid || s1_move);
    assign s1_pix  = !r_s1_op.is_copy ? r_s1_op.value :
                     (r_s1_fwd ? r_s1_fwd_val : r_s1_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op      <= i_op;
            r_s1_rd      <= r_hist[i_op.rd_addr];
            r_s1_fwd     <= s1_move && r_s1_op.has_px
                            && (r_s1_op.pos[HistAw-1:0] == i_op.rd_addr);
            r_s1_fwd_val <= s1_pix;
        end
        if (s1_move && r_s1_op.has_px) begin
            r_hist[r_s1_op.pos[HistAw-1:0]] <= s1_pix;
        end
        if (s1_move) begin
            r_out.pixel_valid    <= r_s1_op.has_px;
            r_out.pixel_value    <= r_s1_op.has_px ? s1_pix : 8'd0;
            r_out.pixel_position <= r_s1_op.pos;
            r_out.copy_pending   <= r_s1_op.pend;
            r_out.status         <= r_s1_op.status;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// File: src/lz_flag_bit_pixel_decompressor.sv
// Top level of the flag-bit LZ pixel decompressor.
// Depends on lzfb_pkg, lzfb_front, lzfb_queue and lzfb_back.
//
//  Channel  | Signals                       | Direction
//  ---------+-------------------------------+-----------------------------
//  request  | i_valid, o_stall, i_data      | in: byte push or copy advance
//  result   | o_valid, i_stall, o_data      | out: pixel or status report
//  config   | i_cfg_we, i_cfg_addr, i_cfg_data | in: packet/frame size
//
// One request is accepted per cycle while o_stall is low. The decoder settles the
// full token state for a request in its accept cycle; its result is then registered
// in the two-entry queue, the history RAM read stage and the result register before
// it is offered.
// Reset is synchronous and active low; the history RAM is not cleared.
// A stalled result backs up the back end, then the two-entry queue, and only
// then raises o_stall; requests that make no result still need queue room.
`default_nettype none
module lz_flag_bit_pixel_decompressor (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [0:0]            i_cfg_addr,
    input  wire [16:0]           i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  lzfb_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  wire                  i_stall,
    output lzfb_pkg::t_out_item  o_data
);
    import lzfb_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_nonempty;
    t_op  f_op;
    t_op  q_op;

    // The decoder proceeds while the queue has room. The full flag comes from
    // the queue's count register, so the result stall never reaches o_stall
    // in the same cycle.
    assign o_stall = q_full;
    assign accept  = i_valid && !o_stall;

    lzfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_data),
        .o_push     (push),
        .o_op       (f_op)
    );

    lzfb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_op       (f_op),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_op       (q_op)
    );

    lzfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_nonempty),
        .i_op    (q_op),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire
